>>> rtl/dvfs_ea_pkg.sv
// ============================================================================
// dvfs_ea_pkg: shared types and constants of the DVFS energy accumulator
// Command, status and register codes, fixed field widths, the shared
// multiplier operand widths and the saturating helpers of the power sum.
// ============================================================================
`default_nettype none

package dvfs_ea_pkg;

   // Command codes carried in tuser of a request transaction
   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_TICK   = 2'd0;
   localparam cmd_type CMD_ADD    = 2'd1;
   localparam cmd_type CMD_REMOVE = 2'd2;
   localparam cmd_type CMD_WRITE  = 2'd3;

   // Status codes carried in tuser of a response transaction
   typedef logic [1:0] status_type;
   localparam status_type STAT_OK        = 2'd0;
   localparam status_type STAT_BACKWARDS = 2'd1;
   localparam status_type STAT_SATURATED = 2'd2;

   // Register indexes (byte address / 4)
   typedef logic [1:0] reg_idx_type;
   localparam reg_idx_type REG_ACTIVITY = 2'd0;
   localparam reg_idx_type REG_STATIC   = 2'd1;
   localparam reg_idx_type REG_TOP_GEAR = 2'd2;

   // Field widths
   localparam int TIME_W   = 48;
   localparam int ENERGY_W = 64;
   localparam int POWER_W  = 48;
   localparam int FREQ_W   = 16;
   localparam int VOLT_W   = 16;
   localparam int ACT_W    = 16;
   localparam int ALPHA_W  = 32;
   localparam int TOPG_W   = 3;
   localparam int GIDX_W   = 3;
   localparam int CPU_W    = 13;

   // Port widths
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 112;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Shared multiplier: A holds up to act*dyn (50 bits), B a count (<= 17 bits)
   localparam int MUL_A_W = 50;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Fixed-point alignment
   localparam int VSQ_SHIFT  = 14;
   localparam int VSQ_W      = 18;
   localparam int DYN_W      = 34;
   localparam int DYN_SHIFT  = 16;
   localparam int STAT_SHIFT = 14;
   localparam int CHUNK_W    = 16;

   // Clamp a product to the power range
   function automatic logic [POWER_W-1:0] clamp_power(input logic [MUL_P_W-1:0] p);
      return (|p[MUL_P_W-1:POWER_W]) ? {POWER_W{1'b1}} : p[POWER_W-1:0];
   endfunction

   // Add two power values, saturating at the top of the power range
   function automatic logic [POWER_W-1:0] sat_add_power(input logic [POWER_W-1:0] a,
                                                         input logic [POWER_W-1:0] b);
      logic [POWER_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[POWER_W] ? {POWER_W{1'b1}} : s[POWER_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/dvfs_ea_mul.sv
// ============================================================================
// dvfs_ea_mul: shared registered multiplier
// One unsigned product per cycle, registered and available in the cycle after
// the operands are presented.
// ============================================================================
`default_nettype none

module dvfs_ea_mul (
   input  logic                            clock,
   input  logic [dvfs_ea_pkg::MUL_A_W-1:0] op_a,
   input  logic [dvfs_ea_pkg::MUL_B_W-1:0] op_b,
   output logic [dvfs_ea_pkg::MUL_P_W-1:0] prod
);
   import dvfs_ea_pkg::*;

   logic [MUL_P_W-1:0] prod_ff;

   // Register the full product
   always_ff @(posedge clock) begin
      prod_ff <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

>>> rtl/dvfs_ea_gear_ram.sv
// ============================================================================
// dvfs_ea_gear_ram: gear entry memory
// One entry per gear holding {count, voltage, frequency}; one write port,
// one read port with registered data. Entries never written read as zero.
// ============================================================================
`default_nettype none

module dvfs_ea_gear_ram #(
   parameter int NUM_GEARS = 8,
   parameter int ENTRY_W   = 45
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [$clog2(NUM_GEARS)-1:0] rd_addr,
   output logic [ENTRY_W-1:0]           rd_data,
   input  logic                         wr_en,
   input  logic [$clog2(NUM_GEARS)-1:0] wr_addr,
   input  logic [ENTRY_W-1:0]           wr_data
);
   logic [ENTRY_W-1:0]   gear_mem [NUM_GEARS];
   logic [NUM_GEARS-1:0] valid_ff;
   logic [ENTRY_W-1:0]   rd_q_ff;
   logic                 rd_valid_ff;

   // Write the entry array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         gear_mem[wr_addr] <= wr_data;
      end
   end

   // Track written entries
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Read into a registered data output
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff <= gear_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // Unwritten entries read as zero
   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

`default_nettype wire

>>> rtl/dvfs_energy_accumulator_core.sv
// ============================================================================
// dvfs_energy_accumulator_core: DVFS dynamic plus static energy accumulator
// Walks the gear memory on each tick, forms the interval power with one
// shared multiplier and adds elapsed time times power to a saturating sum.
// ============================================================================
//
//   Channel   Direction  Handshake                  Payload
//   req_      in         tvalid/tready              tdata: item fields, tuser: command
//   rsp_      out        tvalid/tready              tdata: energy, power, tuser: status
//   csr_      in         psel/penable/pwrite/pready 3 registers at 0x0, 0x4, 0x8
//
// A tick steps through gears 0 to T, with T the effective top gear: eight
// multiplier steps per gear, five for the elapsed*power product and the energy
// add, then result hand-off and idle. Count and table commands pass through
// memory read, write back and hand-off; one whose gear index lies outside the
// table skips the memory. Reset is synchronous; the gear memory needs no
// clearing pass. A stalled response holds in the output register and the
// sequencer waits in its last step until that register has room; the next
// request is taken in the cycle after.
//
`default_nettype none

module dvfs_energy_accumulator_core #(
   parameter int NUM_GEARS = 8,
   parameter int MAX_CPUS  = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   // time[47:0] active[60:48] total[73:61] gear_index[76:74] cpu_delta[89:77]
   // gear_frequency[105:90] gear_voltage[121:106], zero fill above
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [dvfs_ea_pkg::REQ_DATA_W-1:0] req_tdata,
   // command[1:0]
   input  logic [1:0]                         req_tuser,
   // energy_total[63:0] interval_power[111:64]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [dvfs_ea_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]                         rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dvfs_ea_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [dvfs_ea_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [dvfs_ea_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                               csr_pready
);
   import dvfs_ea_pkg::*;

   localparam int GW      = $clog2(NUM_GEARS);
   localparam int CW      = $clog2(MAX_CPUS + 1);
   localparam int RW      = CW + GW;
   localparam int ENTRY_W = FREQ_W + VOLT_W + CW;

   // Sequencer states
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RMW  = 4'd1;
   localparam logic [3:0] S_VV   = 4'd2;
   localparam logic [3:0] S_FV   = 4'd3;
   localparam logic [3:0] S_ID   = 4'd4;
   localparam logic [3:0] S_AD   = 4'd5;
   localparam logic [3:0] S_XC   = 4'd6;
   localparam logic [3:0] S_AC   = 4'd7;
   localparam logic [3:0] S_SV   = 4'd8;
   localparam logic [3:0] S_SA   = 4'd9;
   localparam logic [3:0] S_E2   = 4'd10;
   localparam logic [3:0] S_E1   = 4'd11;
   localparam logic [3:0] S_E0   = 4'd12;
   localparam logic [3:0] S_EF   = 4'd13;
   localparam logic [3:0] S_EA   = 4'd14;
   localparam logic [3:0] S_OUT  = 4'd15;

   // Configuration registers
   logic [ACT_W-1:0]   act_ff;
   logic [ALPHA_W-1:0] alpha_ff;
   logic [TOPG_W-1:0]  top_ff;

   // Control and working registers
   logic [3:0]          state_ff, state_in;
   logic [GW-1:0]       g_ff, g_in;
   cmd_type             cmd_ff, cmd_in;
   logic [GW-1:0]       gidx_ff, gidx_in;
   logic [CPU_W-1:0]    delta_ff, delta_in;
   logic [FREQ_W-1:0]   freq_ff, freq_in;
   logic [VOLT_W-1:0]   volt_ff, volt_in;
   logic [CW-1:0]       active_ff, active_in;
   logic [CW-1:0]       total_ff, total_in;
   logic [RW-1:0]       reduced_ff, reduced_in;
   logic [POWER_W-1:0]  acc_ff, acc_in;
   logic [DYN_W-1:0]    dyn_ff, dyn_in;
   logic [TIME_W-1:0]   elapsed_ff, elapsed_in;
   logic [ENERGY_W-1:0] pacc_ff, pacc_in;
   logic                povf_ff, povf_in;
   status_type          status_ff, status_in;
   logic [ENERGY_W-1:0] energy_ff, energy_in;
   logic [TIME_W-1:0]   last_time_ff, last_time_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ENERGY_W-1:0] rsp_energy_ff, rsp_energy_in;
   logic [POWER_W-1:0]  rsp_power_ff, rsp_power_in;
   status_type          rsp_status_ff, rsp_status_in;

   // Memory and multiplier hookup
   logic               rd_en;
   logic [GW-1:0]      rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic               wr_en;
   logic [ENTRY_W-1:0] wr_data;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] mul_p;

   // Request fields
   logic                accept;
   logic [TIME_W-1:0]   req_time;
   logic [31:0]         req_active32;
   logic [31:0]         req_total32;
   logic [31:0]         active_clamp32;
   logic [31:0]         total_clamp32;
   logic [7:0]          req_gidx8;
   logic                gidx_ok;

   // Derived values
   logic [7:0]          top8;
   logic [GW-1:0]       top_eff;
   logic                is_top;
   logic [FREQ_W-1:0]   ent_freq;
   logic [VOLT_W-1:0]   ent_volt;
   logic [CW-1:0]       ent_count;
   logic [CW-1:0]       idle_cnt;
   logic [RW-1:0]       active_ext;
   logic [RW-1:0]       total_ext;
   logic [RW-1:0]       run_w;
   logic [RW-1:0]       unr_w;
   logic [31:0]         cnt32;
   logic [31:0]         dlt32;
   logic [31:0]         add32;
   logic [31:0]         new_cnt32;
   status_type          rmw_status;
   logic [ENERGY_W:0]   pstep;
   logic                pstep_ovf;
   logic [ENERGY_W-1:0] prod_sat;
   logic [ENERGY_W:0]   esum;
   logic                out_load;

   // Unpack the request
   assign accept         = req_tvalid & req_tready;
   assign req_tready     = (state_ff == S_IDLE);
   assign req_time       = req_tdata[47:0];
   assign req_active32   = 32'(req_tdata[60:48]);
   assign req_total32    = 32'(req_tdata[73:61]);
   assign active_clamp32 = (req_active32 > 32'(MAX_CPUS)) ? 32'(MAX_CPUS) : req_active32;
   assign total_clamp32  = (req_total32 > 32'(MAX_CPUS)) ? 32'(MAX_CPUS) : req_total32;
   assign req_gidx8      = 8'(req_tdata[76:74]);
   assign gidx_ok        = (req_gidx8 < 8'(NUM_GEARS));

   // Clamp the top gear into the table
   assign top8    = (8'(top_ff) >= 8'(NUM_GEARS)) ? 8'(NUM_GEARS - 1) : 8'(top_ff);
   assign top_eff = top8[GW-1:0];
   assign is_top  = (g_ff == top_eff);

   // Split the gear entry
   assign ent_freq  = rd_data[FREQ_W-1:0];
   assign ent_volt  = rd_data[FREQ_W +: VOLT_W];
   assign ent_count = rd_data[ENTRY_W-1:FREQ_W+VOLT_W];

   // Processor counts at the top gear, floored at zero
   assign idle_cnt   = (total_ff > active_ff) ? total_ff - active_ff : '0;
   assign active_ext = RW'(active_ff);
   assign total_ext  = RW'(total_ff);
   assign run_w      = (active_ext > reduced_ff) ? active_ext - reduced_ff : '0;
   assign unr_w      = (total_ext > reduced_ff) ? total_ext - reduced_ff : '0;

   // Count update for add and remove commands
   assign cnt32 = 32'(ent_count);
   assign dlt32 = 32'(delta_ff);
   assign add32 = cnt32 + dlt32;

   always_comb begin
      new_cnt32  = cnt32;
      rmw_status = STAT_OK;
      case (cmd_ff)
         CMD_ADD: begin
            if (add32 > 32'(MAX_CPUS)) begin
               new_cnt32  = 32'(MAX_CPUS);
               rmw_status = STAT_SATURATED;
            end else begin
               new_cnt32 = add32;
            end
         end
         CMD_REMOVE: begin
            if (dlt32 > cnt32) begin
               new_cnt32  = '0;
               rmw_status = STAT_SATURATED;
            end else begin
               new_cnt32 = cnt32 - dlt32;
            end
         end
         default: begin
            new_cnt32 = cnt32;
         end
      endcase
   end

   assign wr_data = (cmd_ff == CMD_WRITE) ? {ent_count, volt_ff, freq_ff}
                                          : {new_cnt32[CW-1:0], ent_volt, ent_freq};

   // One Horner step of elapsed*power, sticky on overflow
   assign pstep     = {1'b0, pacc_ff[ENERGY_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}}
                    + {1'b0, mul_p[ENERGY_W-1:0]};
   assign pstep_ovf = (|pacc_ff[ENERGY_W-1:ENERGY_W-CHUNK_W]) | pstep[ENERGY_W];
   assign prod_sat  = povf_ff ? {ENERGY_W{1'b1}} : pacc_ff;
   assign esum      = {1'b0, energy_ff} + {1'b0, prod_sat};

   // Select multiplier operands for each step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_VV: begin
            mul_a = MUL_A_W'(ent_volt);
            mul_b = MUL_B_W'(ent_volt);
         end
         S_FV: begin
            mul_a = MUL_A_W'(mul_p[VSQ_SHIFT +: VSQ_W]);
            mul_b = MUL_B_W'(ent_freq);
         end
         S_ID: begin
            mul_a = MUL_A_W'(mul_p[DYN_W-1:0]);
            mul_b = is_top ? MUL_B_W'(idle_cnt) : '0;
         end
         S_AD: begin
            mul_a = MUL_A_W'(dyn_ff);
            mul_b = MUL_B_W'(act_ff);
         end
         S_XC: begin
            mul_a = mul_p[MUL_A_W-1:0];
            mul_b = is_top ? MUL_B_W'(run_w[CW-1:0]) : MUL_B_W'(ent_count);
         end
         S_AC: begin
            mul_a = MUL_A_W'(alpha_ff);
            mul_b = is_top ? MUL_B_W'(unr_w[CW-1:0]) : MUL_B_W'(ent_count);
         end
         S_SV: begin
            mul_a = mul_p[MUL_A_W-1:0];
            mul_b = MUL_B_W'(ent_volt);
         end
         S_E2: begin
            mul_a = MUL_A_W'(elapsed_ff);
            mul_b = MUL_B_W'(acc_ff[POWER_W-1:2*CHUNK_W]);
         end
         S_E1: begin
            mul_a = MUL_A_W'(elapsed_ff);
            mul_b = MUL_B_W'(acc_ff[2*CHUNK_W-1:CHUNK_W]);
         end
         S_E0: begin
            mul_a = MUL_A_W'(elapsed_ff);
            mul_b = MUL_B_W'(acc_ff[CHUNK_W-1:0]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Sequence one item through memory, multiplier and accumulators
   always_comb begin
      state_in     = state_ff;
      g_in         = g_ff;
      cmd_in       = cmd_ff;
      gidx_in      = gidx_ff;
      delta_in     = delta_ff;
      freq_in      = freq_ff;
      volt_in      = volt_ff;
      active_in    = active_ff;
      total_in     = total_ff;
      reduced_in   = reduced_ff;
      acc_in       = acc_ff;
      dyn_in       = dyn_ff;
      elapsed_in   = elapsed_ff;
      pacc_in      = pacc_ff;
      povf_in      = povf_ff;
      status_in    = status_ff;
      energy_in    = energy_ff;
      last_time_in = last_time_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      out_load     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in     = req_tuser;
               gidx_in    = req_gidx8[GW-1:0];
               delta_in   = req_tdata[89:77];
               freq_in    = req_tdata[105:90];
               volt_in    = req_tdata[121:106];
               active_in  = active_clamp32[CW-1:0];
               total_in   = total_clamp32[CW-1:0];
               reduced_in = '0;
               acc_in     = '0;
               g_in       = '0;
               status_in  = STAT_OK;
               if (req_tuser == CMD_TICK) begin
                  // Elapsed time, zero when time went backwards
                  if (req_time >= last_time_ff) begin
                     elapsed_in = req_time - last_time_ff;
                  end else begin
                     elapsed_in = '0;
                     status_in  = STAT_BACKWARDS;
                  end
                  last_time_in = req_time;
                  rd_en        = 1'b1;
                  rd_addr      = '0;
                  state_in     = S_VV;
               end else if (gidx_ok) begin
                  rd_en    = 1'b1;
                  rd_addr  = req_gidx8[GW-1:0];
                  state_in = S_RMW;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_RMW: begin
            wr_en     = 1'b1;
            status_in = rmw_status;
            state_in  = S_OUT;
         end
         S_VV: begin
            state_in = S_FV;
         end
         S_FV: begin
            state_in = S_ID;
         end
         S_ID: begin
            dyn_in   = mul_p[DYN_W-1:0];
            state_in = S_AD;
         end
         S_AD: begin
            // Idle term (zero below the top gear)
            acc_in   = sat_add_power(acc_ff, clamp_power(mul_p));
            state_in = S_XC;
         end
         S_XC: begin
            state_in = S_AC;
         end
         S_AC: begin
            // Dynamic term
            acc_in   = sat_add_power(acc_ff, clamp_power(mul_p >> DYN_SHIFT));
            state_in = S_SV;
         end
         S_SV: begin
            state_in = S_SA;
         end
         S_SA: begin
            // Static term, then advance to the next gear or to energy
            acc_in = sat_add_power(acc_ff, clamp_power(mul_p >> STAT_SHIFT));
            if (is_top) begin
               state_in = S_E2;
            end else begin
               reduced_in = reduced_ff + RW'(ent_count);
               g_in       = g_ff + GW'(1);
               rd_en      = 1'b1;
               rd_addr    = g_ff + GW'(1);
               state_in   = S_VV;
            end
         end
         S_E2: begin
            state_in = S_E1;
         end
         S_E1: begin
            pacc_in  = mul_p[ENERGY_W-1:0];
            povf_in  = 1'b0;
            state_in = S_E0;
         end
         S_E0: begin
            pacc_in  = pstep[ENERGY_W-1:0];
            povf_in  = povf_ff | pstep_ovf;
            state_in = S_EF;
         end
         S_EF: begin
            pacc_in  = pstep[ENERGY_W-1:0];
            povf_in  = povf_ff | pstep_ovf;
            state_in = S_EA;
         end
         S_EA: begin
            energy_in = esum[ENERGY_W] ? {ENERGY_W{1'b1}} : esum[ENERGY_W-1:0];
            state_in  = S_OUT;
         end
         S_OUT: begin
            // Hand the result over once the output register has room
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: load on completion, drop when taken
   always_comb begin
      rsp_energy_in = rsp_energy_ff;
      rsp_power_in  = rsp_power_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (out_load) begin
         rsp_energy_in = energy_ff;
         rsp_power_in  = acc_ff;
         rsp_status_in = status_ff;
         rsp_valid_in  = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         energy_ff    <= '0;
         last_time_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         energy_ff    <= energy_in;
         last_time_ff <= last_time_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      g_ff          <= g_in;
      cmd_ff        <= cmd_in;
      gidx_ff       <= gidx_in;
      delta_ff      <= delta_in;
      freq_ff       <= freq_in;
      volt_ff       <= volt_in;
      active_ff     <= active_in;
      total_ff      <= total_in;
      reduced_ff    <= reduced_in;
      acc_ff        <= acc_in;
      dyn_ff        <= dyn_in;
      elapsed_ff    <= elapsed_in;
      pacc_ff       <= pacc_in;
      povf_ff       <= povf_in;
      status_ff     <= status_in;
      rsp_energy_ff <= rsp_energy_in;
      rsp_power_ff  <= rsp_power_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff   <= ACT_W'(32768);
         alpha_ff <= '0;
         top_ff   <= TOPG_W'(7);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_paddr[3:2])
            REG_ACTIVITY: act_ff   <= csr_pwdata[ACT_W-1:0];
            REG_STATIC:   alpha_ff <= csr_pwdata[ALPHA_W-1:0];
            REG_TOP_GEAR: top_ff   <= csr_pwdata[TOPG_W-1:0];
            default: begin
               act_ff <= act_ff;
            end
         endcase
      end
   end

   // Configuration reads
   always_comb begin
      case (csr_paddr[3:2])
         REG_ACTIVITY: csr_prdata = CSR_DATA_W'(act_ff);
         REG_STATIC:   csr_prdata = CSR_DATA_W'(alpha_ff);
         REG_TOP_GEAR: csr_prdata = CSR_DATA_W'(top_ff);
         default:      csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_power_ff, rsp_energy_ff};
   assign rsp_tuser  = rsp_status_ff;

   dvfs_ea_gear_ram #(
      .NUM_GEARS (NUM_GEARS),
      .ENTRY_W   (ENTRY_W)
   ) u_gear_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (gidx_ff),
      .wr_data (wr_data)
   );

   dvfs_ea_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_p)
   );

endmodule

`default_nettype wire

>>> tb/tb_dvfs_energy_accumulator_core.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_dvfs_energy_accumulator_core: self-checking bench of the energy accumulator
// Streams gear commands and power ticks into the core and predicts, per
// accepted transaction, the energy sum, interval power and status. Compares
// every response field by field. Several register settings are applied
// between drained phases. The sender idles in bursts and the receiver
// stalls on its own pattern, including one long hold-off.
// ============================================================================

module tb_dvfs_energy_accumulator_core;
   import dvfs_ea_pkg::*;

   localparam int NUM_GEARS  = 8;
   localparam int MAX_CPUS   = 4096;
   localparam int LONG_HOLD  = 400;
   localparam int HOLD_AFTER = 120;

   typedef struct {
      cmd_type     cmd;
      logic [47:0] stamp;
      logic [12:0] active;
      logic [12:0] total;
      logic [2:0]  gear;
      logic [12:0] delta;
      logic [15:0] freq;
      logic [15:0] volt;
   } gear_cmd_type;

   typedef struct {
      logic [63:0] energy;
      logic [47:0] power;
      status_type  status;
   } energy_report_type;

   typedef enum logic [1:0] {RX_FLOW, RX_COIN, RX_CHOKE} rx_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = CMD_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   dvfs_energy_accumulator_core #(
      .NUM_GEARS(NUM_GEARS),
      .MAX_CPUS (MAX_CPUS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Shadow copy of the core state and registers
   logic [15:0] m_act   = 16'd32768;
   logic [31:0] m_alpha = 32'd0;
   logic [2:0]  m_top   = 3'd7;
   logic [15:0] m_freq [NUM_GEARS] = '{default: '0};
   logic [15:0] m_volt [NUM_GEARS] = '{default: '0};
   logic [12:0] m_count[NUM_GEARS] = '{default: '0};
   logic [47:0] m_last   = '0;
   logic [63:0] m_energy = '0;

   gear_cmd_type      cmd_backlog[$];
   energy_report_type pending_reports[$];
   int                cmds_queued  = 0;
   int                reports_seen = 0;
   int                fail_count   = 0;
   logic [47:0]       time_cursor  = '0;

   function automatic logic [63:0] sat_mul64(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return (|p[127:64]) ? {64{1'b1}} : p[63:0];
   endfunction

   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

   // f * ((V*V) >> 14) of one gear
   function automatic logic [63:0] gear_dyn(input int g);
      logic [63:0] v;
      v = m_volt[g];
      return 64'(m_freq[g]) * ((v * v) >> VSQ_SHIFT);
   endfunction

   function automatic logic [63:0] switch_power(input logic [63:0] dyn,
                                                input logic [63:0] count);
      return sat_mul64(sat_mul64(64'(m_act), dyn), count) >> DYN_SHIFT;
   endfunction

   function automatic logic [63:0] leak_power(input logic [63:0] count, input int g);
      return sat_mul64(sat_mul64(64'(m_alpha), count), 64'(m_volt[g])) >> STAT_SHIFT;
   endfunction

   function automatic logic [63:0] diff0(input logic [63:0] a, input logic [63:0] b);
      return (a > b) ? a - b : 64'd0;
   endfunction

   // Apply one accepted command to the shadow state and return its report
   function automatic energy_report_type advance_energy_model(input gear_cmd_type c);
      energy_report_type r;
      logic [63:0]       act_n, tot_n, dtop, reduced, power, elapsed, cnt;
      logic [13:0]       sum;
      int                g;
      int                top;
      power    = '0;
      r.status = STAT_OK;
      act_n    = (c.active > MAX_CPUS) ? 64'(MAX_CPUS) : 64'(c.active);
      tot_n    = (c.total > MAX_CPUS) ? 64'(MAX_CPUS) : 64'(c.total);
      case (c.cmd)
         CMD_TICK: begin
            top     = (m_top >= NUM_GEARS) ? NUM_GEARS - 1 : int'(m_top);
            dtop    = gear_dyn(top);
            reduced = '0;
            power   = sat_mul64(diff0(tot_n, act_n), dtop);
            for (g = 0; g < top; g++) begin
               cnt     = 64'(m_count[g]);
               power   = sat_add64(power, switch_power(gear_dyn(g), cnt));
               power   = sat_add64(power, leak_power(cnt, g));
               reduced = reduced + cnt;
            end
            power = sat_add64(power, switch_power(dtop, diff0(act_n, reduced)));
            power = sat_add64(power, leak_power(diff0(tot_n, reduced), top));
            if (power > 64'h0000_FFFF_FFFF_FFFF) begin
               power = 64'h0000_FFFF_FFFF_FFFF;
            end
            // Backward time step: no energy, flag it, still move the mark
            if (c.stamp >= m_last) begin
               elapsed = 64'(c.stamp) - 64'(m_last);
            end else begin
               elapsed  = '0;
               r.status = STAT_BACKWARDS;
            end
            m_energy = sat_add64(m_energy, sat_mul64(elapsed, power));
            m_last   = c.stamp;
         end
         CMD_ADD: begin
            sum = 14'(m_count[c.gear]) + 14'(c.delta);
            if (sum > MAX_CPUS) begin
               sum      = 14'(MAX_CPUS);
               r.status = STAT_SATURATED;
            end
            m_count[c.gear] = sum[12:0];
         end
         CMD_REMOVE: begin
            if (c.delta > m_count[c.gear]) begin
               m_count[c.gear] = '0;
               r.status        = STAT_SATURATED;
            end else begin
               m_count[c.gear] = m_count[c.gear] - c.delta;
            end
         end
         default: begin
            m_freq[c.gear] = c.freq;
            m_volt[c.gear] = c.volt;
         end
      endcase
      r.energy = m_energy;
      r.power  = power[47:0];
      return r;
   endfunction

   function automatic gear_cmd_type make_cmd(input cmd_type cmd, input logic [47:0] stamp,
                                             input int active, input int total,
                                             input int gear, input int delta,
                                             input int freq, input int volt);
      gear_cmd_type c;
      c.cmd    = cmd;
      c.stamp  = stamp;
      c.active = 13'(active);
      c.total  = 13'(total);
      c.gear   = 3'(gear);
      c.delta  = 13'(delta);
      c.freq   = 16'(freq);
      c.volt   = 16'(volt);
      return c;
   endfunction

   // Random command: mostly realistic values, random noise in unused fields
   function automatic gear_cmd_type random_cmd(input bit wide_time);
      gear_cmd_type c;
      int           sel;
      logic [63:0]  r64;
      sel      = $urandom_range(0, 99);
      c.cmd    = (sel < 50) ? CMD_TICK : (sel < 70) ? CMD_ADD :
                 (sel < 85) ? CMD_REMOVE : CMD_WRITE;
      r64      = {$urandom(), $urandom()};
      c.stamp  = r64[47:0];
      c.active = 13'($urandom_range(0, 8191));
      c.total  = 13'($urandom_range(0, 8191));
      c.gear   = 3'($urandom_range(0, NUM_GEARS - 1));
      c.delta  = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 8191))
                                             : 13'($urandom_range(0, 64));
      c.freq   = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                             : 16'($urandom_range(400, 4000));
      c.volt   = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                             : 16'($urandom_range(8000, 20000));
      if (c.cmd == CMD_TICK) begin
         // Keep elapsed time short unless wide_time is set, so the energy sum stays clear of saturation
         if (wide_time) begin
            time_cursor = r64[47:0];
         end else if ($urandom_range(0, 19) == 0 && time_cursor > 0) begin
            time_cursor = time_cursor -
                          48'($urandom_range(1, 32'((time_cursor > 1000) ? 48'd1000
                                                                         : time_cursor)));
         end else begin
            time_cursor = time_cursor + 48'($urandom_range(0, 15));
         end
         c.stamp  = time_cursor;
         c.total  = ($urandom_range(0, 15) == 0) ? 13'($urandom_range(0, 8191))
                                                 : 13'($urandom_range(0, MAX_CPUS));
         c.active = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 8191))
                                                : 13'($urandom_range(0, c.total));
      end
      return c;
   endfunction

   task automatic queue_cmd(input gear_cmd_type c);
      cmd_backlog.push_back(c);
      cmds_queued++;
   endtask

   task automatic queue_random(input int count, input bit wide_time);
      repeat (count) queue_cmd(random_cmd(wide_time));
   endtask

   // Wait until every queued command has been answered
   task automatic wait_drained(input int settle);
      @(posedge clock);
      while (cmd_backlog.size() != 0 || pending_reports.size() != 0 ||
             reports_seen < cmds_queued) begin
         @(posedge clock);
      end
      repeat (settle) @(posedge clock);
   endtask

   // Register write: setup cycle, then access until pready
   task automatic program_reg(input reg_idx_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_ACTIVITY: m_act   = value[15:0];
         REG_STATIC:   m_alpha = value;
         default:      m_top   = value[2:0];
      endcase
   endtask

   // Sender: offer the backlog in bursts with random gaps
   gear_cmd_type in_flight;
   int           burst_left = 0;
   int           gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            pending_reports.push_back(advance_energy_model(in_flight));
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 || cmd_backlog.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               in_flight = cmd_backlog.pop_front();
               req_tdata <= {6'd0, in_flight.volt, in_flight.freq, in_flight.delta,
                             in_flight.gear, in_flight.total, in_flight.active,
                             in_flight.stamp};
               req_tuser  <= in_flight.cmd;
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
               end
            end
         end
      end
   end

   // Receiver: random stall pattern plus one long hold-off
   rx_mode_type rx_mode   = RX_FLOW;
   int          rx_span   = 0;
   int          rx_seen   = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) rx_seen++;
         if (!hold_done && rx_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (rx_span == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 2));
            rx_span = $urandom_range(20, 200);
         end else begin
            rx_span--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_FLOW: rsp_tready <= 1'b1;
               RX_COIN: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 5) == 0);
            endcase
         end
      end
   end

   // Monitor: compare each response with the oldest prediction
   always @(posedge clock) begin
      energy_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         reports_seen++;
         if (pending_reports.size() == 0) begin
            $error("response with no command outstanding: energy %0d power %0d status %0d",
                   rsp_tdata[63:0], rsp_tdata[111:64], rsp_tuser);
            fail_count++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_tdata[63:0] !== want.energy) begin
               $error("energy_total mismatch: expected %0d, actual %0d",
                      want.energy, rsp_tdata[63:0]);
               fail_count++;
            end
            if (rsp_tdata[111:64] !== want.power) begin
               $error("interval_power mismatch: expected %0d, actual %0d",
                      want.power, rsp_tdata[111:64]);
               fail_count++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d", want.status, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   // Stimulus phases
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset register values, table writes, count limits, tick corners
      queue_cmd(make_cmd(CMD_TICK,   48'd0,  0,    0,    0, 0,    0,     0));
      queue_cmd(make_cmd(CMD_WRITE,  48'd0,  0,    0,    7, 0,    2000,  16384));
      queue_cmd(make_cmd(CMD_WRITE,  48'd0,  0,    0,    0, 0,    65535, 65535));
      queue_cmd(make_cmd(CMD_WRITE,  48'd0,  0,    0,    3, 0,    0,     0));
      queue_cmd(make_cmd(CMD_WRITE,  48'd0,  0,    0,    1, 0,    1200,  12000));
      queue_cmd(make_cmd(CMD_ADD,    48'd0,  0,    0,    0, 100,  0,     0));
      queue_cmd(make_cmd(CMD_ADD,    48'd0,  0,    0,    3, 8191, 0,     0));
      queue_cmd(make_cmd(CMD_REMOVE, 48'd0,  0,    0,    3, 96,   0,     0));
      queue_cmd(make_cmd(CMD_REMOVE, 48'd0,  0,    0,    5, 1,    0,     0));
      queue_cmd(make_cmd(CMD_ADD,    48'd0,  0,    0,    5, 0,    0,     0));
      queue_cmd(make_cmd(CMD_TICK,   48'd10, 50,   200,  0, 0,    0,     0));
      // Time going backwards, active above total
      queue_cmd(make_cmd(CMD_TICK,   48'd5,  300,  100,  0, 0,    0,     0));
      // Same time again, processor counts above the machine size
      queue_cmd(make_cmd(CMD_TICK,   48'd5,  8191, 8191, 0, 0,    0,     0));
      queue_cmd(make_cmd(CMD_TICK,   48'd12, 0,    8191, 0, 0,    0,     0));
      // Top gear count: exactly full, then one past
      queue_cmd(make_cmd(CMD_ADD,    48'd0,  0,    0,    7, 4096, 0,     0));
      queue_cmd(make_cmd(CMD_ADD,    48'd0,  0,    0,    7, 1,    0,     0));
      queue_cmd(make_cmd(CMD_REMOVE, 48'd0,  0,    0,    0, 100,  0,     0));
      // Reduced count above both active and total
      queue_cmd(make_cmd(CMD_ADD,    48'd0,  0,    0,    1, 4000, 0,     0));
      queue_cmd(make_cmd(CMD_TICK,   48'd20, 100,  1000, 0, 0,    0,     0));
      queue_cmd(make_cmd(CMD_WRITE,  48'd0,  0,    0,    7, 0,    65535, 65535));
      queue_cmd(make_cmd(CMD_TICK,   48'd21, 4096, 4096, 0, 0,    0,     0));
      queue_cmd(make_cmd(CMD_WRITE,  48'd0,  0,    0,    7, 0,    1800,  14000));
      queue_cmd(make_cmd(CMD_TICK,   48'd24, 2000, 4096, 0, 0,    0,     0));
      wait_drained(8);

      // Mid-range setting; the long receiver hold-off falls in here
      program_reg(REG_ACTIVITY, 32'($urandom_range(1000, 60000)));
      program_reg(REG_STATIC, 32'($urandom_range(1, 5000)));
      program_reg(REG_TOP_GEAR, 32'd7);
      queue_random(600, 1'b0);
      wait_drained(8);

      // Full activity, largest leakage coefficient
      program_reg(REG_ACTIVITY, 32'd65535);
      program_reg(REG_STATIC, 32'hFFFF_FFFF);
      queue_random(300, 1'b0);
      wait_drained(8);

      // No activity, no leakage, no reduced gears
      program_reg(REG_ACTIVITY, 32'd0);
      program_reg(REG_STATIC, 32'd0);
      program_reg(REG_TOP_GEAR, 32'd0);
      queue_random(300, 1'b0);
      wait_drained(8);

      // Random setting with a middle top gear
      program_reg(REG_ACTIVITY, 32'($urandom_range(0, 65535)));
      program_reg(REG_STATIC, 32'($urandom_range(0, 1 << 20)));
      program_reg(REG_TOP_GEAR, 32'($urandom_range(1, 6)));
      queue_random(280, 1'b0);
      wait_drained(8);

      // Full time range last: drive the energy sum into saturation
      program_reg(REG_ACTIVITY, 32'd32768);
      program_reg(REG_STATIC, 32'h0000_1234);
      program_reg(REG_TOP_GEAR, 32'd7);
      queue_cmd(make_cmd(CMD_TICK, 48'hFFFF_FFFF_FFFF, 4096, 4096, 0, 0, 0, 0));
      queue_cmd(make_cmd(CMD_TICK, 48'd0,              1000, 4096, 0, 0, 0, 0));
      queue_cmd(make_cmd(CMD_TICK, 48'hFFFF_FFFF_FFFF, 0,    4096, 0, 0, 0, 0));
      queue_random(40, 1'b1);
      wait_drained(100);

      if (pending_reports.size() != 0) begin
         $error("%0d predicted responses never arrived", pending_reports.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
